### hdl/bdc_pkg.sv
// Shared types and constants for the B-dot detumbling controller.
package bdc_pkg;

  localparam int FIELD_W    = 21;
  localparam int RATE_W     = 16;
  localparam int PERIOD_W   = 16;
  localparam int GAIN_W     = 24;
  localparam int LIMIT_W    = 20;
  localparam int THRESH_W   = 15;
  localparam int NEED_W     = 16;
  localparam int STEPS_W    = 32;
  localparam int MAG_W      = 21;
  localparam int PROD_W     = GAIN_W + MAG_W;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_CYCLES = PROD_W / DIV_STEPS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Z   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_THR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CALM_NEED = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_CLAMP,
    ST_FIN
  } state_t;

endpackage

### hdl/bdc_div.sv
// Iterative restoring divider, three quotient bits per cycle.
module bdc_div import bdc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [PROD_W-1:0]   dividend,
  input  logic [PERIOD_W-1:0] divisor,
  output logic                done,
  output logic [PROD_W-1:0]   quotient
);

  logic [PROD_W-1:0]   dq_r, dq_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;
  logic [PERIOD_W-1:0] dvs_r;
  logic [4:0]          cnt_r;
  logic                busy_r;
  logic                done_r;

  always_comb begin
    logic [PERIOD_W:0] t;
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t      = {rem_nxt, dq_nxt[PROD_W-1]};
      dq_nxt = {dq_nxt[PROD_W-2:0], 1'b0};
      if (t >= {1'b0, dvs_r}) begin
        rem_nxt   = PERIOD_W'(t - {1'b0, dvs_r});
        dq_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[PERIOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

### hdl/bdot_detumble_controller_core.sv
// Top level of the proportional B-dot detumbling controller.
//
// Usage:
//   in_*  : one transfer per sensor sample: field x/y/z (nT), rate x/y/z (mrad/s)
//           and step period (ms). Accepted when in_tvalid and in_tready are high.
//   out_* : one transfer per sample: clamped dipole x/y/z, steps taken, and the
//           done flag on out_tuser.
//   cfg_* : register writes (index, data); always ready. Write only while idle.
// Sequence:
//   after an accepted sample, the shared multiplier squares the rates and the
//   threshold while the squared rates are summed; then per axis one multiply,
//   one divider start, the divider's iterations at 3 quotient bits each over a
//   45-bit product, the divider's done, a clamp; then the result is posted
//   once the output register can take it. in_tready is high only while the
//   sequencer idles, so one sample is in work at a time and the next sample
//   is taken only after the result of the last one has been posted.
// Reset (rst_n low, synchronous): registers take defaults, stored field and
//   both counters clear, channels empty.
// Stall: a result waits in the output register; the next sample may be taken
//   and worked, and its result is held back (in_tready low) until the waiting
//   one transfers.
module bdot_detumble_controller_core import bdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // field_x, field_y, field_z, rate_x, rate_y, rate_z, step_period, zero pad
  input  logic [127:0]          in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // dipole_x, dipole_y, dipole_z, steps_taken, zero pad
  output logic [95:0]           out_tdata,
  // done_res
  output logic                  out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready
);

  // configuration
  logic [GAIN_W-1:0]   gain_r;
  logic [LIMIT_W-1:0]  lim_r [3];
  logic [THRESH_W-1:0] thr_r;
  logic [NEED_W-1:0]   need_r;

  // persistent state
  logic signed [FIELD_W-1:0] prev_r [3];
  logic [NEED_W-1:0]         calm_cnt_r;
  logic [STEPS_W-1:0]        step_total_r;

  // per-sample working registers
  state_t              state_r, state_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [1:0]          ax_r, ax_nxt;
  logic [MAG_W-1:0]    mag_r [3];
  logic                pos_r [3];
  logic [RATE_W-1:0]   rate_r [3];
  logic [PERIOD_W-1:0] period_r;
  logic [STEPS_W-1:0]  sum_r;
  logic                calm_r;
  logic [PROD_W-1:0]   prod_r;
  logic [FIELD_W-1:0]  dip_r [3];

  // output register
  logic                out_valid_r;
  logic [95:0]         out_data_r;
  logic                out_user_r;

  logic                in_accept;
  logic                out_load;
  logic signed [FIELD_W:0] diff [3];
  logic                all_zero;
  logic [GAIN_W-1:0]   mul_a;
  logic [MAG_W-1:0]    mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [PROD_W-9:0]   q_mag;
  logic [LIMIT_W-1:0]  m_clamp;
  logic [NEED_W-1:0]   calm_next;
  logic                div_start;
  logic                div_done;
  logic [PROD_W-1:0]   div_q;

  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // field differences against the stored sample
  always_comb begin
    logic signed [FIELD_W-1:0] f;
    for (int i = 0; i < 3; i++) begin
      f       = in_tdata[FIELD_W*i +: FIELD_W];
      diff[i] = {f[FIELD_W-1], f} - {prev_r[i][FIELD_W-1], prev_r[i]};
    end
    all_zero = (diff[0] == '0) && (diff[1] == '0) && (diff[2] == '0);
  end

  // shared multiplier: rate squares, threshold square, then gain * |diff|
  always_comb begin
    mul_a = gain_r;
    mul_b = mag_r[ax_r];
    if (state_r == ST_SQR) begin
      if (cnt_r == 3'd3) begin
        mul_a = GAIN_W'(thr_r);
        mul_b = MAG_W'(thr_r);
      end else begin
        mul_a = GAIN_W'(rate_r[cnt_r[1:0]]);
        mul_b = MAG_W'(rate_r[cnt_r[1:0]]);
      end
    end
  end
  assign mul_p = mul_a * mul_b;

  bdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (period_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // drop the 8 fraction bits, clamp to the axis limit
  assign q_mag   = div_q[PROD_W-1:8];
  assign m_clamp = (q_mag > (PROD_W-8)'(lim_r[ax_r])) ? lim_r[ax_r] : q_mag[LIMIT_W-1:0];

  assign calm_next = calm_r ? ((calm_cnt_r == '1) ? calm_cnt_r : calm_cnt_r + 1'b1) : '0;
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ax_nxt    = ax_r;
    div_start = 1'b0;
    in_tready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SQR;
          cnt_nxt   = '0;
        end
      end
      ST_SQR: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          state_nxt = ST_MUL;
          ax_nxt    = '0;
        end
      end
      ST_MUL:    state_nxt = ST_DSTART;
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (ax_r == 2'd2) begin
          state_nxt = ST_FIN;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ax_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ax_r    <= ax_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= 24'd65536;
      lim_r[0] <= 20'd200000;
      lim_r[1] <= 20'd200000;
      lim_r[2] <= 20'd200000;
      thr_r    <= 15'd17;
      need_r   <= 16'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN:      gain_r   <= cfg_data;
        REG_LIMIT_X:   lim_r[0] <= cfg_data[LIMIT_W-1:0];
        REG_LIMIT_Y:   lim_r[1] <= cfg_data[LIMIT_W-1:0];
        REG_LIMIT_Z:   lim_r[2] <= cfg_data[LIMIT_W-1:0];
        REG_RATE_THR:  thr_r    <= cfg_data[THRESH_W-1:0];
        REG_CALM_NEED: need_r   <= cfg_data[NEED_W-1:0];
        default: ;
      endcase
    end
  end

  // stored field and step counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r[0]    <= '0;
      prev_r[1]    <= '0;
      prev_r[2]    <= '0;
      calm_cnt_r   <= '0;
      step_total_r <= '0;
    end else begin
      if (in_accept) begin
        for (int i = 0; i < 3; i++) prev_r[i] <= in_tdata[FIELD_W*i +: FIELD_W];
      end
      if (out_load) begin
        calm_cnt_r <= calm_next;
        if (step_total_r != '1) step_total_r <= step_total_r + 1'b1;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < 3; i++) begin
        logic [RATE_W-1:0] r;
        r = in_tdata[63 + RATE_W*i +: RATE_W];
        rate_r[i] <= r[RATE_W-1] ? RATE_W'(-r) : r;
        if (all_zero) begin
          mag_r[i] <= MAG_W'(1);
          pos_r[i] <= 1'b1;
        end else begin
          mag_r[i] <= diff[i][FIELD_W] ? MAG_W'(-diff[i]) : MAG_W'(diff[i]);
          pos_r[i] <= !diff[i][FIELD_W] && (diff[i] != '0);
        end
      end
      // zero period runs as 1 ms
      period_r <= (in_tdata[126:111] == '0) ? PERIOD_W'(1) : in_tdata[126:111];
    end
    if (state_r == ST_SQR || state_r == ST_MUL) prod_r <= mul_p;
    if (state_r == ST_SQR) begin
      case (cnt_r)
        3'd1:      sum_r <= prod_r[STEPS_W-1:0];
        3'd2,
        3'd3:      sum_r <= sum_r + prod_r[STEPS_W-1:0];
        3'd4:      calm_r <= (sum_r < prod_r[STEPS_W-1:0]);
        default: ;
      endcase
    end
    if (state_r == ST_CLAMP) begin
      dip_r[ax_r] <= pos_r[ax_r] ? FIELD_W'(-{1'b0, m_clamp}) : {1'b0, m_clamp};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {1'b0,
                     (step_total_r == '1) ? step_total_r : step_total_r + 1'b1,
                     dip_r[2], dip_r[1], dip_r[0]};
      out_user_r <= (calm_next >= need_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  // one sample in work at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider done outside divide state");

  // after a result is posted the step total is nonzero
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> step_total_r != '0 && out_tvalid)
    else $error("step total not advanced on result");
`endif

endmodule

### tb/bdot_detumble_controller_core_tb.sv
// Self-checking testbench for the B-dot detumbling controller core.
module bdot_detumble_controller_core_tb;
  import bdc_pkg::*;

  localparam int      CLK_HALF       = 6;
  localparam longint  CLK_PERIOD     = 2 * CLK_HALF;
  // leaves a wide margin over the whole run
  localparam longint  TIMEOUT_CYCLES = 600000;
  localparam int      RESET_CYCLES   = 11;
  localparam int      PHASE_ITEMS    = 100;
  localparam int      NUM_PHASES     = 8;
  localparam int      TAIL_CYCLES    = 80;
  localparam int      LONG_STALL     = 600;

  // indexes past the register map; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // one expected command, as it should leave on out_tdata / out_tuser
  typedef struct packed {
    logic [FIELD_W-1:0] dipole_x;
    logic [FIELD_W-1:0] dipole_y;
    logic [FIELD_W-1:0] dipole_z;
    logic               done;
    logic [STEPS_W-1:0] steps;
  } bdot_cmd_t;

  // Shadow of the controller: register copy, stored field, calm and step
  // counters. Each accepted sample yields exactly one expected command.
  class bdot_scoreboard;
    logic [GAIN_W-1:0]         gain;
    logic [LIMIT_W-1:0]        lim [3];
    logic [THRESH_W-1:0]       rate_thr;
    logic [NEED_W-1:0]         calm_need;
    logic signed [FIELD_W-1:0] last_field [3];
    logic [15:0]               calm_count;
    logic [STEPS_W-1:0]        step_total;
    bdot_cmd_t                 cmd_q [$];
    int                        errors;

    function new();
      int i;
      gain      = 24'd65536;
      rate_thr  = 15'd17;
      calm_need = 16'd10;
      for (i = 0; i < 3; i++) begin
        lim[i]        = 20'd200000;
        last_field[i] = '0;
      end
      calm_count = '0;
      step_total = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_GAIN:      gain      = data[GAIN_W-1:0];
        REG_LIMIT_X:   lim[0]    = data[LIMIT_W-1:0];
        REG_LIMIT_Y:   lim[1]    = data[LIMIT_W-1:0];
        REG_LIMIT_Z:   lim[2]    = data[LIMIT_W-1:0];
        REG_RATE_THR:  rate_thr  = data[THRESH_W-1:0];
        REG_CALM_NEED: calm_need = data[NEED_W-1:0];
        default: ;
      endcase
    endfunction

    // magnitude path, truncating toward zero, then clamp and sign flip
    function logic [FIELD_W-1:0] axis_cmd(longint diff, longint unsigned per,
                                          logic [LIMIT_W-1:0] limit_val);
      longint unsigned mag;
      longint unsigned g;
      longint unsigned q;
      longint          cmd;
      mag = (diff < 0) ? -diff : diff;
      g   = gain;
      q   = ((g * mag) / per) >> 8;
      if (q > limit_val) q = limit_val;
      cmd = (diff > 0) ? -longint'(q) : longint'(q);
      return cmd[FIELD_W-1:0];
    endfunction

    function void note_sample(logic [127:0] d);
      logic signed [FIELD_W-1:0] f [3];
      longint                    diff [3];
      longint                    rx, ry, rz;
      longint unsigned           per, sq, th;
      bdot_cmd_t                 c;
      int                        i;
      f[0] = d[20:0];
      f[1] = d[41:21];
      f[2] = d[62:42];
      rx   = longint'($signed(d[78:63]));
      ry   = longint'($signed(d[94:79]));
      rz   = longint'($signed(d[110:95]));
      per  = d[126:111];
      if (per == 0) per = 1;
      for (i = 0; i < 3; i++) diff[i] = longint'(f[i]) - longint'(last_field[i]);
      // unchanged field on all axes: every axis acts as a +1 nT step
      if (diff[0] == 0 && diff[1] == 0 && diff[2] == 0) begin
        for (i = 0; i < 3; i++) diff[i] = 1;
      end
      c.dipole_x = axis_cmd(diff[0], per, lim[0]);
      c.dipole_y = axis_cmd(diff[1], per, lim[1]);
      c.dipole_z = axis_cmd(diff[2], per, lim[2]);
      for (i = 0; i < 3; i++) last_field[i] = f[i];
      sq = rx * rx + ry * ry + rz * rz;
      th = rate_thr;
      th = th * th;
      if (sq < th) begin
        if (calm_count != 16'hFFFF) calm_count++;
      end else begin
        calm_count = '0;
      end
      if (step_total != '1) step_total++;
      c.done  = (calm_count >= calm_need);
      c.steps = step_total;
      cmd_q.push_back(c);
    endfunction

    function void report(string what, longint unsigned exp_v, longint unsigned act_v);
      if (errors < 10) $display("mismatch %s: expected %0h, got %0h", what, exp_v, act_v);
      errors++;
    endfunction

    function void check_result(logic [95:0] d, logic done);
      bdot_cmd_t c;
      if (cmd_q.size() == 0) begin
        report("unrequested command (steps)", 0, d[94:63]);
        return;
      end
      c = cmd_q.pop_front();
      if (d[20:0]  !== c.dipole_x) report("dipole_x", c.dipole_x, d[20:0]);
      if (d[41:21] !== c.dipole_y) report("dipole_y", c.dipole_y, d[41:21]);
      if (d[62:42] !== c.dipole_z) report("dipole_z", c.dipole_z, d[62:42]);
      if (d[94:63] !== c.steps)    report("steps_taken", c.steps, d[94:63]);
      if (done     !== c.done)     report("done_res", c.done, done);
    endfunction

    function int pending();
      return cmd_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  // field_x, field_y, field_z, rate_x, rate_y, rate_z, step_period, zero pad
  logic [127:0]          in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  // dipole_x, dipole_y, dipole_z, steps_taken, zero pad
  logic [95:0]           out_tdata;
  // done_res
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  cfg_valid;
  logic                  cfg_ready;

  int                        send_idle_pct;
  int                        recv_idle_pct;
  int                        stall_left;
  logic signed [FIELD_W-1:0] gen_field [3];
  bdot_scoreboard            sb;

  always #CLK_HALF clk = ~clk;

  bdot_detumble_controller_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  // Monitor: every handshake is sampled at the rising edge, before the
  // block's own updates land, so transfers are seen exactly as the DUT sees them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_sample(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  // Result side backpressure. A long hold-off, counted here, lets the output
  // register fill and the sequencer stall so in_tready stays low for a while.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hard stop in case a transfer never completes.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one sample; random idle cycles go in front of it. Entered and left
  // at a falling edge. tvalid stays high on return so back-to-back samples
  // never see it dropped and raised in one step.
  task automatic send_sample(input logic [127:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Register write on the cfg channel; caller drops cfg_valid after a batch.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [GAIN_W-1:0] g, input logic [LIMIT_W-1:0] lx,
                            input logic [LIMIT_W-1:0] ly, input logic [LIMIT_W-1:0] lz,
                            input logic [THRESH_W-1:0] th, input logic [NEED_W-1:0] need);
    cfg_write(REG_GAIN, CFG_DATA_W'(g));
    cfg_write(REG_LIMIT_X, CFG_DATA_W'(lx));
    cfg_write(REG_LIMIT_Y, CFG_DATA_W'(ly));
    cfg_write(REG_LIMIT_Z, CFG_DATA_W'(lz));
    cfg_write(REG_RATE_THR, CFG_DATA_W'(th));
    cfg_write(REG_CALM_NEED, CFG_DATA_W'(need));
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait until every command has come back; the block is
  // idle afterwards since each sample yields exactly one command.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [127:0] pack_sample(int fx, int fy, int fz,
                                               int rx, int ry, int rz, int per);
    gen_field[0] = FIELD_W'(fx);
    gen_field[1] = FIELD_W'(fy);
    gen_field[2] = FIELD_W'(fz);
    return {1'b0, PERIOD_W'(per), RATE_W'(rz), RATE_W'(ry), RATE_W'(rx),
            FIELD_W'(fz), FIELD_W'(fy), FIELD_W'(fx)};
  endfunction

  // Random sample. Mostly a plausible trajectory: small field steps from the
  // last sample, short periods and rates inside the calm band so the calm
  // counter can run up to done. The rest is full-range noise.
  function automatic logic [127:0] make_sample();
    logic signed [FIELD_W-1:0] f [3];
    logic [RATE_W-1:0]         r [3];
    logic [PERIOD_W-1:0]       per;
    int                        kind, k, h, delta, i;
    kind = $urandom_range(99);
    h    = sb.rate_thr / 2;
    for (i = 0; i < 3; i++) begin
      if (kind < 10 || $urandom_range(7) == 0) begin
        f[i] = gen_field[i];
      end else if (kind < 60) begin
        k     = $urandom_range(12);
        delta = int'($urandom_range(2 << k)) - (1 << k);
        f[i]  = gen_field[i] + FIELD_W'(delta);
      end else begin
        f[i] = FIELD_W'($urandom());
      end
      if ($urandom_range(99) < 70) r[i] = RATE_W'(int'($urandom_range(2 * h)) - h);
      else r[i] = RATE_W'($urandom());
    end
    k = $urandom_range(99);
    if (k < 60) per = PERIOD_W'($urandom_range(16, 1));
    else if (k < 85) per = PERIOD_W'($urandom_range(65535, 1));
    else if (k < 97) per = k[0] ? 16'hFFFF : 16'd1;
    else per = '0;
    for (i = 0; i < 3; i++) gen_field[i] = f[i];
    return {1'b0, per, r[2], r[1], r[0], f[2], f[1], f[0]};
  endfunction

  initial begin
    int phase, i;
    sb            = new();
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tdata      = '0;
    in_tvalid     = 1'b0;
    out_tready    = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    cfg_valid     = 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 59;
    stall_left    = 0;
    for (i = 0; i < 3; i++) gen_field[i] = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on reset defaults.
    // unchanged (zero) field twice: substitute +1 nT step on each axis
    send_sample(pack_sample(0, 0, 0, 0, 0, 0, 1));
    send_sample(pack_sample(0, 0, 0, 0, 0, 0, 1));
    // full-scale field swings, both clamp directions, extreme rates
    send_sample(pack_sample(1048575, 1048575, 1048575, 32767, 32767, 32767, 1));
    send_sample(pack_sample(-1048576, -1048576, -1048576, -32768, -32768, -32768, 1));
    // zero period acts as 1 ms; y unchanged gives a zero dipole on that axis
    send_sample(pack_sample(-1048476, -1048576, -1048566, 0, 0, 0, 0));
    // rate exactly on the threshold is not calm, one below is
    send_sample(pack_sample(0, 5, -5, 17, 0, 0, 65535));
    send_sample(pack_sample(1, 4, -4, 16, 0, 0, 2));
    send_sample(pack_sample(0, 4, -3, 0, -17, 0, 3));
    send_sample(pack_sample(-1, 4, -3, 0, 0, -16, 7));
    send_sample(pack_sample(1048575, -1048576, 0, 10, -9, 9, 1));
    // calm run long enough to raise done
    for (i = 0; i < 11; i++) send_sample(pack_sample(i * 3, -i * 7, i, 5, -5, 5, i + 1));
    drain();
    // zero calm requirement forces done; writes past the map are dropped
    cfg_write(REG_CALM_NEED, '0);
    cfg_write(REG_UNUSED_LO, '1);
    cfg_write(REG_UNUSED_HI, 24'h5A5A5A);
    cfg_valid <= 1'b0;
    send_sample(pack_sample(0, 0, 0, -32768, 0, 0, 4));
    send_sample(pack_sample(0, 0, 0, 0, 0, 0, 4));

    // Random phases, each on its own register setting.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0: set_config(24'd65536, LIMIT_W'($urandom()), LIMIT_W'($urandom()),
                      LIMIT_W'($urandom()), 15'd17, NEED_W'($urandom_range(4, 1)));
        1: set_config('1, '1, '0, LIMIT_W'($urandom()),
                      THRESH_W'($urandom_range(60, 2)), NEED_W'($urandom_range(6, 1)));
        2: set_config('0, 20'd200000, 20'd200000, 20'd200000, '0, 16'd1);
        3: set_config(GAIN_W'($urandom()), LIMIT_W'($urandom()), LIMIT_W'($urandom()),
                      LIMIT_W'($urandom()), '1, 16'd1);
        4: set_config(GAIN_W'($urandom_range(65535)), LIMIT_W'($urandom()),
                      LIMIT_W'($urandom()), LIMIT_W'($urandom()),
                      THRESH_W'($urandom_range(200, 1)), NEED_W'($urandom_range(12, 1)));
        5: set_config(GAIN_W'($urandom()), '1, '1, '1, '1, '1);
        6: set_config(GAIN_W'($urandom()), LIMIT_W'($urandom()), LIMIT_W'($urandom()),
                      LIMIT_W'($urandom()), THRESH_W'($urandom_range(100, 1)),
                      NEED_W'($urandom_range(8, 1)));
        default: set_config(GAIN_W'($urandom()), LIMIT_W'($urandom()),
                            LIMIT_W'($urandom()), LIMIT_W'($urandom()),
                            THRESH_W'($urandom()), NEED_W'($urandom_range(16, 1)));
      endcase
      // idle profile: sender-light first, then receiver-light, then none
      if (phase < 3) begin
        send_idle_pct = 21;
        recv_idle_pct = 59;
      end else if (phase < 6) begin
        send_idle_pct = 59;
        recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // block the result side while the sender keeps offering samples
      if (phase == 1) stall_left = LONG_STALL;
      for (i = 0; i < PHASE_ITEMS; i++) send_sample(make_sample());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
